>>> sv/mtmf_pkg.sv
// Package for the median and trimmed-mean filter: types, sizes and state codes.
// Used by the controller, datapath and top level; depends on nothing.
`default_nettype none
package mtmf_pkg;
  localparam int MaxSamples = 32;
  localparam int SampleBits = 16;
  localparam int IdxBits = $clog2(MaxSamples);
  localparam int CntBits = $clog2(MaxSamples + 1);
  localparam int AccBits = SampleBits + CntBits + 1;

  typedef struct packed {
    logic [15:0] sample;
    logic        last;
  } in_item_t;

  typedef struct packed {
    logic [15:0] filtered;
    logic        overflow;
  } out_item_t;

  typedef enum logic [3:0] {
    StLoad, StCopy, StSortRd, StSortCmp, StPick, StAvgRd, StAvgMul, StDiv, StOut
  } state_e;

  typedef struct packed {
    logic store_wr;
    logic win_clear;
    logic sort_start;
    logic sort_step;
    logic avg_start;
    logic avg_step;
    logic div_start;
    logic div_step;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic sort_done;
    logic avg_done;
    logic div_done;
  } sts_t;
endpackage
`default_nettype wire

>>> sv/mtmf_ctrl.sv
// Controller of the filter: sequences loading, sorting, averaging and output.
// Depends on mtmf_pkg.
`default_nettype none
module mtmf_ctrl import mtmf_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  input  wire logic      in_last_i,
  input  wire logic      out_valid_i,
  input  wire logic      out_ready_i,
  input  wire logic      median_i,
  input  wire sts_t      sts_i,
  output cmd_t           cmd_o,
  output logic           in_ready_o
);
  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StLoad;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      StLoad: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.store_wr = 1'b1;
          if (in_last_i) begin
            cmd_o.sort_start = 1'b1;
            state_d = StSortRd;
          end
        end
      end
      StSortRd: begin
        if (sts_i.sort_done) begin
          state_d = StPick;
        end else begin
          state_d = StSortCmp;
        end
      end
      StSortCmp: begin
        cmd_o.sort_step = 1'b1;
        state_d = StSortRd;
      end
      StPick: begin
        cmd_o.avg_start = 1'b1;
        state_d = StAvgRd;
      end
      StAvgRd: begin
        if (sts_i.avg_done) begin
          state_d = StOut;
        end else begin
          state_d = StAvgMul;
        end
      end
      StAvgMul: begin
        cmd_o.div_start = 1'b1;
        state_d = StDiv;
      end
      StDiv: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_done) begin
          cmd_o.avg_step = 1'b1;
          state_d = median_i ? StOut : StAvgRd;
        end
      end
      StOut: begin
        if (!out_valid_i || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          cmd_o.win_clear = 1'b1;
          state_d = StLoad;
        end
      end
      default: state_d = StLoad;
    endcase
  end

`ifndef SYNTH
  a_ready_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> state_q == StLoad) else $error("ready outside load");
  a_out_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |=> state_q == StLoad) else $error("bad state after output");
  a_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.sort_start |-> cmd_o.store_wr) else $error("sort without last write");
`endif
endmodule
`default_nettype wire

>>> sv/mtmf_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing.
`default_nettype none
module mtmf_ram #(
  parameter int Width = 16,
  parameter int Depth = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

>>> sv/mtmf_dp.sv
// Datapath of the filter: window store, insertion sort, running mean and divider.
// Depends on mtmf_pkg and mtmf_ram.
`default_nettype none
module mtmf_dp import mtmf_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire cmd_t      cmd_i,
  input  wire in_item_t  in_i,
  input  wire logic [7:0] width_i,
  output sts_t           sts_o,
  output logic           median_o,
  output out_item_t      out_o,
  output logic           out_valid_o,
  input  wire logic      out_ready_i
);
  // The sort is an insertion sort over the RAM, one compare a pass through
  // read and compare states. cur_q holds the value being inserted.
  logic [CntBits-1:0]    cnt_q, cnt_d;
  logic                  drop_q, drop_d;
  logic [CntBits-1:0]    n_q;
  logic [CntBits-1:0]    i_q;
  logic [IdxBits-1:0]    j_q;
  logic                  phase_q;
  logic                  shift_c;
  logic [SampleBits-1:0] cur_q;
  logic [IdxBits-1:0]    raddr, waddr;
  logic [SampleBits-1:0] wdata, rdata;
  logic                  we;
  logic [CntBits-1:0]    k_q, cnt_avg_q, start_c, end_c, a_c, half_n;
  logic [SampleBits-1:0] avg_q;
  logic                  med_q;
  logic [AccBits-1:0]    rem_q, num_c;
  logic [SampleBits-1:0] quo_q;
  logic [CntBits-1:0]    divisor_q;
  logic [$clog2(SampleBits+1)-1:0] dbit_q;
  logic                  drop_out_q;
  logic [AccBits-1:0]    prod_c;

  assign half_n = n_q >> 1;
  assign a_c = ({1'b0, width_i} > 9'(n_q)) ? n_q : CntBits'(width_i);
  assign start_c = half_n - (a_c >> 1);
  assign end_c = ((half_n + (a_c >> 1)) >= n_q) ? n_q - 1'b1 : half_n + (a_c >> 1);

  always_comb begin
    cnt_d = cnt_q;
    drop_d = drop_q;
    if (cmd_i.store_wr) begin
      if (cnt_q < CntBits'(MaxSamples)) begin
        cnt_d = cnt_q + 1'b1;
      end else begin
        drop_d = 1'b1;
      end
    end
    if (cmd_i.win_clear) begin
      cnt_d = '0;
      drop_d = 1'b0;
    end
  end

  // A compare shifts buf[j-1] up while it is larger than the value inserted.
  assign shift_c = (j_q != '0) && (rdata > cur_q);

  // RAM port use: load writes, sort reads i or j-1 and shifts, average reads k.
  always_comb begin
    we = 1'b0;
    waddr = cnt_q[IdxBits-1:0];
    wdata = in_i.sample;
    if (cmd_i.avg_start) begin
      raddr = IdxBits'(start_c);
    end else if (med_q) begin
      raddr = IdxBits'(k_q);
    end else if (phase_q) begin
      raddr = j_q - 1'b1;
    end else begin
      raddr = IdxBits'(i_q);
    end
    if (cmd_i.store_wr) begin
      we = cnt_q < CntBits'(MaxSamples);
    end else if (cmd_i.sort_step && phase_q) begin
      we = 1'b1;
      waddr = j_q;
      wdata = shift_c ? rdata : cur_q;
    end
  end

  mtmf_ram #(.Width(SampleBits), .Depth(MaxSamples)) u_ram (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rdata)
  );

  // Sort bookkeeping: phase 0 fetches buf[i] into cur, phase 1 walks j down.
  assign sts_o.sort_done = !phase_q && (i_q >= n_q);
  assign sts_o.avg_done = med_q && (k_q > end_c);
  assign sts_o.div_done = dbit_q == 0;
  assign median_o = width_i == 8'd0;

  assign prod_c = AccBits'(avg_q) * AccBits'(cnt_avg_q);
  assign num_c = prod_c + AccBits'(rdata);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      drop_q <= 1'b0;
      out_valid_o <= 1'b0;
      phase_q <= 1'b0;
      med_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      drop_q <= drop_d;
      if (cmd_i.out_load) begin
        out_valid_o <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_o <= 1'b0;
      end
      if (cmd_i.sort_start) begin
        phase_q <= 1'b0;
      end else if (cmd_i.sort_step) begin
        if (!phase_q) begin
          phase_q <= 1'b1;
        end else if (!shift_c) begin
          phase_q <= 1'b0;
        end
      end
      if (cmd_i.avg_start) begin
        med_q <= 1'b1;
      end else if (cmd_i.out_load) begin
        med_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.sort_start) begin
      n_q <= cnt_d;
      drop_out_q <= drop_d;
      i_q <= CntBits'(1);
    end
    if (cmd_i.sort_step) begin
      if (!phase_q) begin
        cur_q <= rdata;
        j_q <= IdxBits'(i_q);
      end else if (shift_c) begin
        j_q <= j_q - 1'b1;
      end else begin
        i_q <= i_q + 1'b1;
      end
    end
    if (cmd_i.avg_start) begin
      k_q <= start_c;
      cnt_avg_q <= '0;
      avg_q <= '0;
    end
    if (cmd_i.div_start) begin
      rem_q <= num_c;
      divisor_q <= cnt_avg_q + 1'b1;
      quo_q <= '0;
      dbit_q <= ($clog2(SampleBits+1))'(SampleBits);
    end else if (cmd_i.div_step && dbit_q != 0) begin
      if ((rem_q >> (dbit_q - 1'b1)) >= AccBits'(divisor_q)) begin
        rem_q <= rem_q - (AccBits'(divisor_q) << (dbit_q - 1'b1));
        quo_q[($clog2(SampleBits))'(dbit_q - 1'b1)] <= 1'b1;
      end
      dbit_q <= dbit_q - 1'b1;
    end
    if (cmd_i.avg_step) begin
      avg_q <= median_o ? rdata : quo_q;
      k_q <= k_q + 1'b1;
      cnt_avg_q <= cnt_avg_q + 1'b1;
    end
    if (cmd_i.out_load) begin
      out_o.filtered <= avg_q;
      out_o.overflow <= drop_out_q;
    end
  end

`ifndef SYNTH
  a_cnt_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntBits'(MaxSamples)) else $error("count beyond capacity");
  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.win_clear |=> cnt_q == 0 && !drop_q) else $error("window not cleared");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o) else $error("result lost");
`endif
endmodule
`default_nettype wire

>>> sv/median_trimmed_mean_filter.sv
// Top level of the median and trimmed-mean filter: APB register, controller and datapath.
// Depends on mtmf_pkg, mtmf_ctrl and mtmf_dp.
//
// Samples arrive on the input channel, one transaction per cycle while the
// window loads. A transaction with last set closes the window; the block then
// insertion-sorts the held samples in its window RAM, one compare per pass
// through its read and compare states, and either picks the median or forms
// the running mean, each mean step taking a bit-serial division. The median
// takes one such step. One result transaction follows per window, holding
// filtered and overflow. A result waits in its output register while the
// receiver stalls; the next window is accepted as soon as the result has
// moved into that register, and a further result waits until the receiver
// has taken the previous one.
// Reset empties the window, clears the dropped flag, drops any pending result
// and sets average_width to zero. The window RAM needs no clearing.
`default_nettype none
module median_trimmed_mean_filter import mtmf_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire in_item_t    in_data_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output out_item_t        out_data_o,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [1:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  logic [7:0] width_q;
  cmd_t cmd;
  sts_t sts;
  logic median;

  assign pready = 1'b1;
  assign prdata = (paddr == 2'd0) ? {24'd0, width_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q <= '0;
    end else if (psel && penable && pwrite && paddr == 2'd0) begin
      width_q <= pwdata[7:0];
    end
  end

  mtmf_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_last_i(in_data_i.last),
    .out_valid_i(out_valid_o), .out_ready_i, .median_i(median),
    .sts_i(sts), .cmd_o(cmd), .in_ready_o
  );

  mtmf_dp u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .in_i(in_data_i), .width_i(width_q),
    .sts_o(sts), .median_o(median), .out_o(out_data_o),
    .out_valid_o, .out_ready_i
  );
endmodule
`default_nettype wire
